// ----- rtl/rti_pkg.sv -----
package rti_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} reg_idx_t;

	localparam int REG_INDEX_W = 3;

	// 2d projection used for the barycentric weights
	typedef enum logic [1:0] {
		PROJ_XY = 2'd0,
		PROJ_XZ = 2'd1,
		PROJ_YZ = 2'd2
	} proj_t;

	typedef struct packed {
		proj_t proj;
		logic  none;
	} ctl_t;

	// slots of the per-projection weight terms
	localparam int PRM_A  = 0;
	localparam int PRM_C  = 1;
	localparam int PRM_E  = 2;
	localparam int PRM_H  = 3;
	localparam int PRM_U2 = 4;
	localparam int PRM_W2 = 5;
	localparam int PRM_N  = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

endpackage

// ----- rtl/ray_triangle_intersect.sv -----
// Ray/triangle intersection in signed fixed point (COORD_WIDTH bits, FRAC_BITS
// fraction bits, every step saturating). The user is to set the ray through
// the register port while the block is idle; the block does not enforce this.
// Triangles then stream in, one per cycle while in_stall is low, and each
// gives exactly one result in order: a hit flag with the hit point and the
// three barycentric weights, all zero on a miss. The two bit-per-stage
// dividers run in series, t first and then the weights. The front
// pipeline (edges, normal, plane dot products, projection choice) feeds a
// four-entry queue, so an output stall holds the back pipeline and the front
// keeps taking triangles until the queue fills.
module ray_triangle_intersect #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rti_pkg::REG_INDEX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]              cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_WIDTH-1:0]       v0_x,
	input  logic signed [COORD_WIDTH-1:0]       v0_y,
	input  logic signed [COORD_WIDTH-1:0]       v0_z,
	input  logic signed [COORD_WIDTH-1:0]       v1_x,
	input  logic signed [COORD_WIDTH-1:0]       v1_y,
	input  logic signed [COORD_WIDTH-1:0]       v1_z,
	input  logic signed [COORD_WIDTH-1:0]       v2_x,
	input  logic signed [COORD_WIDTH-1:0]       v2_y,
	input  logic signed [COORD_WIDTH-1:0]       v2_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic signed [COORD_WIDTH-1:0]       hit_x,
	output logic signed [COORD_WIDTH-1:0]       hit_y,
	output logic signed [COORD_WIDTH-1:0]       hit_z,
	output logic signed [COORD_WIDTH-1:0]       bary_0,
	output logic signed [COORD_WIDTH-1:0]       bary_1,
	output logic signed [COORD_WIDTH-1:0]       bary_2
);

	localparam int W  = COORD_WIDTH;
	localparam int PW = rti_pkg::PRM_N * W;
	localparam int QW = $bits(rti_pkg::ctl_t) + 3 * W + PW;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] ONE  = (FRAC_BITS < W - 1) ? (W'(1) << FRAC_BITS) : MAXV;

	logic [2:0][W-1:0] org_q, dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			dir_q <= {ONE, {(2*W){1'b0}}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				rti_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data;
				rti_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data;
				rti_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data;
				rti_pkg::REG_DIR_X:    dir_q[0] <= cfg_data;
				rti_pkg::REG_DIR_Y:    dir_q[1] <= cfg_data;
				rti_pkg::REG_DIR_Z:    dir_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [8:0][W-1:0] vtx;

	assign vtx = {v2_z, v2_y, v2_x, v1_z, v1_y, v1_x, v0_z, v0_y, v0_x};

	logic                             f_vld, en_f, en_b, push, pop, q_full, q_empty;
	logic [W-1:0]                     f_num, f_den, f_f, b_num, b_den, b_f;
	logic [rti_pkg::PRM_N-1:0][W-1:0] f_prm, b_prm;
	rti_pkg::ctl_t                    f_ctl, b_ctl;
	logic [QW-1:0]                    q_rd;
	logic [2:0][W-1:0]                pt, bary;

	// front holds only when its last stage cannot transfer into the queue
	assign en_f     = !(f_vld && q_full);
	assign in_stall = !en_f;
	assign push     = f_vld && !q_full;

	assign en_b = !(out_valid && out_stall);
	assign pop  = !q_empty && en_b;

	rti_front #(.W(W), .F(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en_f), .in_vld(in_valid), .vtx(vtx),
		.org(org_q), .dir(dir_q), .vld(f_vld), .num(f_num), .den(f_den),
		.prm(f_prm), .f(f_f), .ctl(f_ctl)
	);

	rti_queue #(.WD(QW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push),
		.wdata({f_ctl, f_f, f_prm, f_num, f_den}), .pop(pop), .rdata(q_rd),
		.full(q_full), .empty(q_empty)
	);

	assign {b_ctl, b_f, b_prm, b_num, b_den} = q_rd;

	rti_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en_b), .pop(pop), .num(b_num), .den(b_den),
		.prm(b_prm), .f(b_f), .ctl(b_ctl), .org(org_q), .dir(dir_q),
		.vld(out_valid), .hit(hit), .pt(pt), .bary(bary)
	);

	assign hit_x  = pt[0];
	assign hit_y  = pt[1];
	assign hit_z  = pt[2];
	assign bary_0 = bary[0];
	assign bary_1 = bary[1];
	assign bary_2 = bary[2];

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_x == '0 && hit_y == '0 && hit_z == '0 &&
			bary_0 == '0 && bary_1 == '0 && bary_2 == '0))
		else $error("miss result carries nonzero fields");

	a_hit_weights: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (bary_0 >= 0 && bary_1 >= 0 && bary_2 >= 0 &&
			bary_0 <= $signed(ONE) && bary_1 <= $signed(ONE) && bary_2 <= $signed(ONE)))
		else $error("hit reported with a weight outside the unit range");

endmodule

// ----- rtl/rti_dly.sv -----
module rti_dly #(
	parameter int WD = 32,
	parameter int N  = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [WD-1:0] d,
	output logic [WD-1:0] q
);

	logic [N-1:0][WD-1:0] pipe_q;

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				pipe_q[k] <= pipe_q[k-1];
			end
		end
	end

	assign q = pipe_q[N-1];

endmodule

// ----- rtl/rti_fmul.sv -----
module rti_fmul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] p
);

	localparam int MW = 2 * W - F;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [MW-1:0] LIM_P = MW'(MAXV);
	localparam logic [MW-1:0] LIM_N = MW'(MAXV) + MW'(1);

	logic [W-1:0]   ma, mb;
	logic [2*W-1:0] prod_s1;
	logic           neg_s1;
	logic [MW-1:0]  m;
	logic [W-1:0]   res;

	assign ma = a[W-1] ? (~a + W'(1)) : a;
	assign mb = b[W-1] ? (~b + W'(1)) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ma * mb;
			neg_s1  <= a[W-1] ^ b[W-1];
		end
	end

	// magnitude truncates toward zero, then sign and clip
	assign m = prod_s1[2*W-1:F];

	always_comb begin
		if (neg_s1) begin
			res = (m > LIM_N) ? MINV : (~m[W-1:0] + W'(1));
		end else begin
			res = (m > LIM_P) ? MAXV : m[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= res;
		end
	end

endmodule

// ----- rtl/rti_fdiv.sv -----
module rti_fdiv #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] q
);

	localparam int NQ = W + F;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
	localparam logic [NQ-1:0] LIM_P = NQ'(MAXV);
	localparam logic [NQ-1:0] LIM_N = NQ'(MAXV) + NQ'(1);

	// one quotient bit per stage; qd shifts the dividend out and the quotient in
	logic [W-1:0]  rem_s [NQ+1];
	logic [NQ-1:0] qd_s  [NQ+1];
	logic [W-1:0]  dvs_s [NQ+1];
	logic          neg_s [NQ+1];
	logic [W-1:0]  ma, mb;
	logic [W-1:0]  res;

	assign ma = a[W-1] ? (~a + W'(1)) : a;
	assign mb = b[W-1] ? (~b + W'(1)) : b;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			qd_s[0]  <= {ma, {F{1'b0}}};
			dvs_s[0] <= mb;
			neg_s[0] <= a[W-1] ^ b[W-1];
		end
	end

	for (genvar k = 0; k < NQ; k++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		logic       take;

		assign trial = {rem_s[k], qd_s[k][NQ-1]};
		assign diff  = trial - {1'b0, dvs_s[k]};
		assign take  = trial >= {1'b0, dvs_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[W-1:0] : trial[W-1:0];
				qd_s[k+1]  <= {qd_s[k][NQ-2:0], take};
				dvs_s[k+1] <= dvs_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	always_comb begin
		if (neg_s[NQ]) begin
			res = (qd_s[NQ] > LIM_N) ? MINV : (~qd_s[NQ][W-1:0] + W'(1));
		end else begin
			res = (qd_s[NQ] > LIM_P) ? MAXV : qd_s[NQ][W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= res;
		end
	end

endmodule

// ----- rtl/rti_queue.sv -----
module rti_queue #(
	parameter int WD = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [WD-1:0] wdata,
	input  logic          pop,
	output logic [WD-1:0] rdata,
	output logic          full,
	output logic          empty
);

	logic [WD-1:0]       mem_q [rti_pkg::QUEUE_DEPTH];
	logic [rti_pkg::QPTR_W-1:0] wr_q, rd_q;
	logic [rti_pkg::QPTR_W:0]   cnt_q;

	assign full  = cnt_q == (rti_pkg::QPTR_W+1)'(rti_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a transfer");

endmodule

// ----- rtl/rti_front.sv -----
module rti_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [8:0][W-1:0]   vtx,
	input  logic [2:0][W-1:0]   org,
	input  logic [2:0][W-1:0]   dir,
	output logic                vld,
	output logic [W-1:0]        num,
	output logic [W-1:0]        den,
	output logic [rti_pkg::PRM_N-1:0][W-1:0] prm,
	output logic [W-1:0]        f,
	output rti_pkg::ctl_t       ctl
);

	localparam int LAST = 8;
	localparam int PW   = rti_pkg::PRM_N * W;

	function automatic logic [W-1:0] clip(input logic [W:0] s);
		clip = (s[W] != s[W-1]) ? {s[W], {(W-1){~s[W]}}} : s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sadd(input logic [W-1:0] x, input logic [W-1:0] y);
		sadd = clip({x[W-1], x} + {y[W-1], y});
	endfunction

	function automatic logic [W-1:0] ssub(input logic [W-1:0] x, input logic [W-1:0] y);
		ssub = clip({x[W-1], x} - {y[W-1], y});
	endfunction

	logic [LAST:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:0], in_vld};
		end
	end

	assign vld = vld_q[LAST];

	logic [8:0][W-1:0]      vtx_s0;
	logic [2:0][2:0][W-1:0] co;

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_s0 <= vtx;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_co
		for (genvar k = 0; k < 3; k++) begin : g_v
			assign co[c][k] = vtx_s0[3*k+c];
		end
	end

	// edges and the vector from origin to the first vertex
	logic [2:0][W-1:0] e1_s1, e2_s1, wv_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				e1_s1[c] <= ssub(co[c][1], co[c][0]);
				e2_s1[c] <= ssub(co[c][2], co[c][0]);
				wv_s1[c] <= ssub(co[c][0], org[c]);
			end
		end
	end

	// cross product
	logic [2:0][W-1:0] xa_s3, xb_s3, n_s4;

	for (genvar c = 0; c < 3; c++) begin : g_cross
		localparam int I1 = (c + 1) % 3;
		localparam int I2 = (c + 2) % 3;

		rti_fmul #(.W(W), .F(F)) u_xa (
			.clk(clk), .en(en), .a(e1_s1[I1]), .b(e2_s1[I2]), .p(xa_s3[c])
		);
		rti_fmul #(.W(W), .F(F)) u_xb (
			.clk(clk), .en(en), .a(e1_s1[I2]), .b(e2_s1[I1]), .p(xb_s3[c])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				n_s4[c] <= ssub(xa_s3[c], xb_s3[c]);
			end
		end
	end

	// weight terms for the xy, xz and yz projections
	logic [2:0][rti_pkg::PRM_N-1:0][W-1:0] prm_s1, prm_s4;
	logic [2:0][W-1:0] g_s1, ae_s3, cg_s3, f_s4;

	for (genvar j = 0; j < 3; j++) begin : g_proj
		localparam int UC = (j == 2) ? 1 : 0;
		localparam int WC = (j == 0) ? 1 : 2;

		always_ff @(posedge clk) begin
			if (en) begin
				prm_s1[j][rti_pkg::PRM_A]  <= ssub(co[WC][1], co[WC][2]);
				prm_s1[j][rti_pkg::PRM_C]  <= ssub(co[UC][2], co[UC][1]);
				prm_s1[j][rti_pkg::PRM_E]  <= ssub(co[UC][0], co[UC][2]);
				prm_s1[j][rti_pkg::PRM_H]  <= ssub(co[WC][2], co[WC][0]);
				prm_s1[j][rti_pkg::PRM_U2] <= co[UC][2];
				prm_s1[j][rti_pkg::PRM_W2] <= co[WC][2];
				g_s1[j]                    <= ssub(co[WC][0], co[WC][2]);
			end
		end

		rti_fmul #(.W(W), .F(F)) u_ae (
			.clk(clk), .en(en), .a(prm_s1[j][rti_pkg::PRM_A]),
			.b(prm_s1[j][rti_pkg::PRM_E]), .p(ae_s3[j])
		);
		rti_fmul #(.W(W), .F(F)) u_cg (
			.clk(clk), .en(en), .a(prm_s1[j][rti_pkg::PRM_C]), .b(g_s1[j]), .p(cg_s3[j])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				f_s4[j] <= sadd(ae_s3[j], cg_s3[j]);
			end
		end
	end

	rti_dly #(.WD(3 * PW), .N(3)) u_prm_dly (
		.clk(clk), .en(en), .d(prm_s1), .q(prm_s4)
	);

	logic [2:0][W-1:0] wv_s4;

	rti_dly #(.WD(3 * W), .N(3)) u_wv_dly (
		.clk(clk), .en(en), .d(wv_s1), .q(wv_s4)
	);

	// first projection whose area is nonzero
	logic [rti_pkg::PRM_N-1:0][W-1:0] sel_s5;
	logic [W-1:0]                     f_s5;
	rti_pkg::ctl_t                    ctl_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			if (f_s4[0] != '0) begin
				sel_s5      <= prm_s4[0];
				f_s5        <= f_s4[0];
				ctl_s5.proj <= rti_pkg::PROJ_XY;
			end else if (f_s4[1] != '0) begin
				sel_s5      <= prm_s4[1];
				f_s5        <= f_s4[1];
				ctl_s5.proj <= rti_pkg::PROJ_XZ;
			end else begin
				sel_s5      <= prm_s4[2];
				f_s5        <= f_s4[2];
				ctl_s5.proj <= rti_pkg::PROJ_YZ;
			end
			ctl_s5.none <= (f_s4[0] == '0) && (f_s4[1] == '0) && (f_s4[2] == '0);
		end
	end

	rti_dly #(.WD($bits(rti_pkg::ctl_t) + W + PW), .N(3)) u_sel_dly (
		.clk(clk), .en(en), .d({ctl_s5, f_s5, sel_s5}), .q({ctl, f, prm})
	);

	// plane dot products: numerator n.(v0-o), denominator n.d
	logic [2:0][W-1:0] mw_s6, md_s6;

	for (genvar c = 0; c < 3; c++) begin : g_dot
		rti_fmul #(.W(W), .F(F)) u_mw (
			.clk(clk), .en(en), .a(n_s4[c]), .b(wv_s4[c]), .p(mw_s6[c])
		);
		rti_fmul #(.W(W), .F(F)) u_md (
			.clk(clk), .en(en), .a(n_s4[c]), .b(dir[c]), .p(md_s6[c])
		);
	end

	logic [W-1:0] sw_s7, cw_s7, sd_s7, cd_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sw_s7 <= sadd(mw_s6[0], mw_s6[1]);
			cw_s7 <= mw_s6[2];
			sd_s7 <= sadd(md_s6[0], md_s6[1]);
			cd_s7 <= md_s6[2];
			num   <= sadd(sw_s7, cw_s7);
			den   <= sadd(sd_s7, cd_s7);
		end
	end

endmodule

// ----- rtl/rti_back.sv -----
module rti_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                pop,
	input  logic [W-1:0]        num,
	input  logic [W-1:0]        den,
	input  logic [rti_pkg::PRM_N-1:0][W-1:0] prm,
	input  logic [W-1:0]        f,
	input  rti_pkg::ctl_t       ctl,
	input  logic [2:0][W-1:0]   org,
	input  logic [2:0][W-1:0]   dir,
	output logic                vld,
	output logic                hit,
	output logic [2:0][W-1:0]   pt,
	output logic [2:0][W-1:0]   bary
);

	localparam int T  = W + F + 2;
	localparam int BL = 2 * T + 10;
	localparam int PW = rti_pkg::PRM_N * W;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] ONE  = (F < W - 1) ? (W'(1) << F) : MAXV;

	function automatic logic [W-1:0] clip(input logic [W:0] s);
		clip = (s[W] != s[W-1]) ? {s[W], {(W-1){~s[W]}}} : s[W-1:0];
	endfunction

	function automatic logic [W-1:0] sadd(input logic [W-1:0] x, input logic [W-1:0] y);
		sadd = clip({x[W-1], x} + {y[W-1], y});
	endfunction

	function automatic logic [W-1:0] ssub(input logic [W-1:0] x, input logic [W-1:0] y);
		ssub = clip({x[W-1], x} - {y[W-1], y});
	endfunction

	function automatic logic in_unit(input logic [W-1:0] x);
		in_unit = !x[W-1] && (x <= ONE);
	endfunction

	logic [BL:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BL-1:0], pop};
		end
	end

	assign vld = vld_q[BL];

	logic [W-1:0]                     num_s0, den_s0, f_s0;
	logic [rti_pkg::PRM_N-1:0][W-1:0] prm_s0;
	rti_pkg::ctl_t                    ctl_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s0 <= num;
			den_s0 <= den;
			f_s0   <= f;
			prm_s0 <= prm;
			ctl_s0 <= ctl;
		end
	end

	// t = num / den
	logic [W-1:0] t;

	rti_fdiv #(.W(W), .F(F)) u_tdiv (
		.clk(clk), .en(en), .a(num_s0), .b(den_s0), .q(t)
	);

	// parallel ray, degenerate normal or no usable projection
	logic kill_fin, tpos_fin;

	rti_dly #(.WD(1), .N(2 * T + 9)) u_kill_dly (
		.clk(clk), .en(en), .d(den_s0 == '0 || ctl_s0.none), .q(kill_fin)
	);
	rti_dly #(.WD(1), .N(T + 9)) u_tpos_dly (
		.clk(clk), .en(en), .d(t != '0 && !t[W-1]), .q(tpos_fin)
	);

	// hit point o + d*t
	logic [2:0][W-1:0] dt_s2, p_s3;

	for (genvar c = 0; c < 3; c++) begin : g_pt
		rti_fmul #(.W(W), .F(F)) u_dt (
			.clk(clk), .en(en), .a(dir[c]), .b(t), .p(dt_s2[c])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				p_s3[c] <= sadd(org[c], dt_s2[c]);
			end
		end
	end

	logic [rti_pkg::PRM_N-1:0][W-1:0] prm_s3, prm_s4;
	rti_pkg::ctl_t                    ctl_s3;
	logic [W-1:0]                     pu, pw, du_s4, dw_s4;

	rti_dly #(.WD($bits(rti_pkg::ctl_t) + PW), .N(T + 3)) u_prm3_dly (
		.clk(clk), .en(en), .d({ctl_s0, prm_s0}), .q({ctl_s3, prm_s3})
	);

	always_comb begin
		unique case (ctl_s3.proj)
			rti_pkg::PROJ_XY: begin
				pu = p_s3[0];
				pw = p_s3[1];
			end
			rti_pkg::PROJ_XZ: begin
				pu = p_s3[0];
				pw = p_s3[2];
			end
			rti_pkg::PROJ_YZ: begin
				pu = p_s3[1];
				pw = p_s3[2];
			end
			default: begin
				pu = p_s3[0];
				pw = p_s3[1];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			du_s4  <= ssub(pu, prm_s3[rti_pkg::PRM_U2]);
			dw_s4  <= ssub(pw, prm_s3[rti_pkg::PRM_W2]);
			prm_s4 <= prm_s3;
		end
	end

	logic [W-1:0] adu_s6, cdw_s6, hdu_s6, edw_s6, n0_s7, n1_s7, f_s7;

	rti_fmul #(.W(W), .F(F)) u_adu (
		.clk(clk), .en(en), .a(prm_s4[rti_pkg::PRM_A]), .b(du_s4), .p(adu_s6)
	);
	rti_fmul #(.W(W), .F(F)) u_cdw (
		.clk(clk), .en(en), .a(prm_s4[rti_pkg::PRM_C]), .b(dw_s4), .p(cdw_s6)
	);
	rti_fmul #(.W(W), .F(F)) u_hdu (
		.clk(clk), .en(en), .a(prm_s4[rti_pkg::PRM_H]), .b(du_s4), .p(hdu_s6)
	);
	rti_fmul #(.W(W), .F(F)) u_edw (
		.clk(clk), .en(en), .a(prm_s4[rti_pkg::PRM_E]), .b(dw_s4), .p(edw_s6)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			n0_s7 <= sadd(adu_s6, cdw_s6);
			n1_s7 <= sadd(hdu_s6, edw_s6);
		end
	end

	rti_dly #(.WD(W), .N(T + 7)) u_f_dly (
		.clk(clk), .en(en), .d(f_s0), .q(f_s7)
	);

	logic [W-1:0] b0, b1;

	rti_fdiv #(.W(W), .F(F)) u_b0div (
		.clk(clk), .en(en), .a(n0_s7), .b(f_s7), .q(b0)
	);
	rti_fdiv #(.W(W), .F(F)) u_b1div (
		.clk(clk), .en(en), .a(n1_s7), .b(f_s7), .q(b1)
	);

	// third weight 1 - w0 - w1, clipped after each step
	logic [W-1:0]      x_s8, b0_s8, b1_s8;
	logic [2:0][W-1:0] b_s9, p_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s8    <= ssub(ONE, b0);
			b0_s8   <= b0;
			b1_s8   <= b1;
			b_s9[0] <= b0_s8;
			b_s9[1] <= b1_s8;
			b_s9[2] <= ssub(x_s8, b1_s8);
		end
	end

	rti_dly #(.WD(3 * W), .N(T + 6)) u_p_dly (
		.clk(clk), .en(en), .d(p_s3), .q(p_s9)
	);

	logic hit_c;

	assign hit_c = !kill_fin && tpos_fin &&
		in_unit(b_s9[0]) && in_unit(b_s9[1]) && in_unit(b_s9[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			hit  <= hit_c;
			pt   <= hit_c ? p_s9 : '0;
			bary <= hit_c ? b_s9 : '0;
		end
	end

endmodule
